// ----- sv/fdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb_pkg: shared definitions for the blending downscaler
// Register indexes, reset values, request flags and the RGB565 and
// accumulator helper functions.
// ----------------------------------------------------------------------------
package fdb_pkg;

	localparam int DEF_MAX_COLUMNS = 1024;
	localparam int DEF_MAX_LINES   = 1024;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SIZE_W     = 11;
	localparam int ACC_W      = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADD_X         = 3'd0,
		CFG_MODULO_X      = 3'd1,
		CFG_ADD_Y         = 3'd2,
		CFG_MODULO_Y      = 3'd3,
		CFG_FRAME_COLUMNS = 3'd4,
		CFG_FRAME_LINES   = 3'd5,
		CFG_BLEND_ROWS    = 3'd6
	} cfg_reg_t;

	localparam logic [15:0]       RST_ADD_X         = 16'd1;
	localparam logic [15:0]       RST_MODULO_X      = 16'd1;
	localparam logic [15:0]       RST_ADD_Y         = 16'd1;
	localparam logic [15:0]       RST_MODULO_Y      = 16'd1;
	localparam logic [SIZE_W-1:0] RST_FRAME_COLUMNS = 11'd320;
	localparam logic [SIZE_W-1:0] RST_FRAME_LINES   = 11'd240;
	localparam logic              RST_BLEND_ROWS    = 1'b1;

	typedef struct packed {
		logic [15:0]       add_x;
		logic [15:0]       modulo_x;
		logic [15:0]       add_y;
		logic [15:0]       modulo_y;
		logic [SIZE_W-1:0] frame_columns;
		logic [SIZE_W-1:0] frame_lines;
		logic              blend_rows;
	} cfg_t;

	// Flags that travel with each line-buffer write request.
	typedef struct packed {
		logic blend;
		logic commit;
		logic fend;
	} op_flags_t;

	// Status of the write-back stage, seen by the top level.
	typedef struct packed {
		logic valid;
		logic go;
		logic commit;
		logic fwd;
	} back_stat_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             reached;
	} acc_res_t;

	function automatic logic [15:0] avg565(input logic [15:0] a, input logic [15:0] b);
		logic [5:0] r;
		logic [6:0] g;
		logic [5:0] bl;
		r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
		g  = {1'b0, a[10:5]} + {1'b0, b[10:5]};
		bl = {1'b0, a[4:0]} + {1'b0, b[4:0]};
		return {r[5:1], g[6:1], bl[5:1]};
	endfunction

	// Steps an accumulator, subtracting the threshold once reached and
	// saturating at the top of its range.
	function automatic acc_res_t acc_step(input logic [ACC_W-1:0] acc,
			input logic [15:0] inc, input logic [15:0] modv);
		acc_res_t   res;
		logic [ACC_W:0] s;
		s = {1'b0, acc} + {2'b00, inc};
		res.reached = (s >= {2'b00, modv});
		if (res.reached) begin
			s = s - {2'b00, modv};
		end
		res.acc = s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- sv/fdb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module fdb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/fdb_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb_fifo: short request queue between classifier and write-back
// Full flag decoded from a registered count; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module fdb_fifo
	import fdb_pkg::*;
#(
	parameter int WIDTH = 16,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  wdata,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             not_empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign rdata     = slot_q[rd_ptr_q];
	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/fdb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb_front: pixel classifier
// Runs the accumulators and counters for each accepted pixel and emits a
// line-buffer write request whenever an output column is produced.
// ----------------------------------------------------------------------------
module fdb_front
	import fdb_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_LINES   = DEF_MAX_LINES
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire cfg_t                   cfg,
	input  wire                         in_go,
	input  wire [15:0]                  src_pixel,
	output logic                        op_push,
	output logic [15:0]                 op_pixel,
	output logic [$clog2(MAX_COLUMNS)-1:0] op_col,
	output logic [$clog2(MAX_LINES)-1:0]   op_row,
	output op_flags_t                   op_flags
);

	localparam int CW  = $clog2(MAX_COLUMNS);
	localparam int RW  = $clog2(MAX_LINES);
	localparam int EWC = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
	localparam int EWR = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

	logic [ACC_W-1:0] acc_horiz_q;
	logic [ACC_W-1:0] acc_vert_q;
	logic [15:0]      running_q;
	logic             blend_pending_q;
	logic             row_commits_q;
	logic [CW-1:0]    src_col_q;
	logic [RW-1:0]    src_row_q;
	logic [CW-1:0]    dst_col_q;
	logic [RW-1:0]    dst_row_q;

	logic [EWC-1:0] fc_e, cols_e;
	logic [EWR-1:0] fl_e, lines_e;
	logic           last_col, last_row, row_start, commit;
	logic [15:0]    pix;
	acc_res_t       hres, vres;

	always_comb begin
		fc_e = EWC'(cfg.frame_columns);
		fl_e = EWR'(cfg.frame_lines);
		if (fc_e == '0) begin
			cols_e = EWC'(1);
		end else if (fc_e > EWC'(MAX_COLUMNS)) begin
			cols_e = EWC'(MAX_COLUMNS);
		end else begin
			cols_e = fc_e;
		end
		if (fl_e == '0) begin
			lines_e = EWR'(1);
		end else if (fl_e > EWR'(MAX_LINES)) begin
			lines_e = EWR'(MAX_LINES);
		end else begin
			lines_e = fl_e;
		end
		last_col  = (EWC'(src_col_q) + EWC'(1)) >= cols_e;
		last_row  = (EWR'(src_row_q) + EWR'(1)) >= lines_e;
		row_start = (src_col_q == '0);
		vres      = acc_step(acc_vert_q, cfg.add_y, cfg.modulo_y);
		commit    = row_start ? (vres.reached || last_row) : row_commits_q;
		pix       = (acc_horiz_q >= {1'b0, cfg.add_x}) ? avg565(running_q, src_pixel)
		                                               : src_pixel;
		hres      = acc_step(acc_horiz_q, cfg.add_x, cfg.modulo_x);
	end

	assign op_push         = in_go && (hres.reached || last_col);
	assign op_pixel        = pix;
	assign op_col          = dst_col_q;
	assign op_row          = dst_row_q;
	assign op_flags.blend  = blend_pending_q;
	assign op_flags.commit = commit;
	assign op_flags.fend   = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_horiz_q     <= '0;
			acc_vert_q      <= '0;
			running_q       <= '0;
			blend_pending_q <= 1'b0;
			row_commits_q   <= 1'b0;
			src_col_q       <= '0;
			src_row_q       <= '0;
			dst_col_q       <= '0;
			dst_row_q       <= '0;
		end else if (in_go) begin
			if (last_col && last_row) begin
				acc_vert_q <= '0;
			end else if (row_start) begin
				acc_vert_q <= vres.acc;
			end
			if (row_start) begin
				row_commits_q <= commit;
			end
			if (last_col) begin
				src_col_q   <= '0;
				acc_horiz_q <= '0;
				running_q   <= '0;
				dst_col_q   <= '0;
				if (last_row) begin
					src_row_q       <= '0;
					dst_row_q       <= '0;
					blend_pending_q <= 1'b0;
				end else begin
					src_row_q       <= src_row_q + 1'b1;
					blend_pending_q <= cfg.blend_rows && !commit;
					if (commit) begin
						dst_row_q <= dst_row_q + 1'b1;
					end
				end
			end else begin
				src_col_q   <= src_col_q + 1'b1;
				acc_horiz_q <= hres.acc;
				running_q   <= pix;
				if (op_push) begin
					dst_col_q <= dst_col_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/fdb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb_back: line-buffer write-back and result register
// Reads the line buffer for each request, blends where asked, writes the
// value back and presents committed values on the result register.
// ----------------------------------------------------------------------------
module fdb_back
	import fdb_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_LINES   = DEF_MAX_LINES
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            head_valid,
	input  wire [15:0]                     head_pixel,
	input  wire [$clog2(MAX_COLUMNS)-1:0]  head_col,
	input  wire [$clog2(MAX_LINES)-1:0]    head_row,
	input  wire op_flags_t                 head_flags,
	output logic                           pop,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [15:0]                    out_pixel,
	output logic [9:0]                     out_x,
	output logic [9:0]                     out_y,
	output logic                           frame_end,
	output back_stat_t                     stat
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_LINES);

	logic            op_valid_s1;
	logic [15:0]     op_pixel_s1;
	logic [CW-1:0]   op_col_s1;
	logic [RW-1:0]   op_row_s1;
	op_flags_t       op_flags_s1;
	logic            fwd_s1;
	logic [15:0]     fwd_data_s1;

	logic [15:0]     ram_rdata, buf_value, wr_value;
	logic            out_free, go, s1_free;
	logic [CW+9:0]   col_wide;
	logic [RW+9:0]   row_wide;

	assign out_free  = !out_valid || !out_stall;
	assign go        = op_valid_s1 && (!op_flags_s1.commit || out_free);
	assign s1_free   = !op_valid_s1 || go;
	assign pop       = head_valid && s1_free;
	assign buf_value = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign wr_value  = op_flags_s1.blend ? avg565(buf_value, op_pixel_s1) : op_pixel_s1;
	assign col_wide  = (CW+10)'(op_col_s1);
	assign row_wide  = (RW+10)'(op_row_s1);

	assign stat.valid  = op_valid_s1;
	assign stat.go     = go;
	assign stat.commit = op_flags_s1.commit;
	assign stat.fwd    = fwd_s1;

	fdb_ram #(
		.WIDTH(16),
		.DEPTH(MAX_COLUMNS)
	) u_line_buf (
		.clk   (clk),
		.we    (go),
		.waddr (op_col_s1),
		.wdata (wr_value),
		.re    (pop),
		.raddr (head_col),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			op_pixel_s1 <= head_pixel;
			op_col_s1   <= head_col;
			op_row_s1   <= head_row;
			op_flags_s1 <= head_flags;
			fwd_data_s1 <= wr_value;
		end
		if (go && op_flags_s1.commit) begin
			out_pixel <= wr_value;
			out_x     <= col_wide[9:0];
			out_y     <= row_wide[9:0];
			frame_end <= op_flags_s1.fend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (s1_free) begin
				op_valid_s1 <= head_valid;
				fwd_s1      <= pop && go && (head_col == op_col_s1);
			end
			if (out_free) begin
				out_valid <= go && op_flags_s1.commit;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/fit_downscaler_with_blending.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted pixel passes the request queue and write-back to the result register.
// Throughput: one pixel per cycle while the request queue has room; the result
// register and the queue let input and output stall independently.
// Reset: arst_n clears all counters, accumulators, queue and valid flags at once and
// loads the register reset values; the line buffer is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// fit_downscaler_with_blending: RGB565 accumulator downscaler with row blending
// Source pixels in raster order are reduced horizontally and vertically by
// add/modulo accumulators; skipped rows may be blended into a line buffer.
// ----------------------------------------------------------------------------
//
// Structure. The classifier (fdb_front) holds every piece of per-frame state
// and, for each accepted pixel, decides whether an output column is produced.
// Such a pixel becomes a write request carrying the horizontally averaged
// value, its output coordinate and three flags: blend with the line buffer,
// commit to the output, and last pixel of the frame. Requests pass through a
// short queue to the write-back stage (fdb_back), which reads the line
// buffer, blends where asked, writes the result back and, for committing
// rows, loads the result register.
//
// The line buffer read is issued when a request enters the write-back stage
// and its registered data is used there. Should the request ahead be writing
// the same column as the read is issued (a row of one output column followed by
// the next row), the freshly written value is forwarded instead.
//
// The input side stalls only when the queue is full, which happens only
// as a result of the output side stalling.
//
module fit_downscaler_with_blending
	import fdb_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_LINES   = DEF_MAX_LINES
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire [15:0]           src_pixel,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [15:0]          out_pixel,
	output logic [9:0]           out_x,
	output logic [9:0]           out_y,
	output logic                 frame_end
);

	localparam int CW   = $clog2(MAX_COLUMNS);
	localparam int RW   = $clog2(MAX_LINES);
	localparam int OP_W = 16 + CW + RW + $bits(op_flags_t);

	cfg_t cfg_q;

	logic            in_go;
	logic            op_push;
	logic [15:0]     op_pixel;
	logic [CW-1:0]   op_col;
	logic [RW-1:0]   op_row;
	op_flags_t       op_flags;

	logic [OP_W-1:0] q_wdata, q_rdata;
	logic            q_full, q_not_empty, q_pop;

	logic [15:0]     head_pixel;
	logic [CW-1:0]   head_col;
	logic [RW-1:0]   head_row;
	op_flags_t       head_flags;
	back_stat_t      back_stat;

	// Configuration registers; writes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.add_x         <= RST_ADD_X;
			cfg_q.modulo_x      <= RST_MODULO_X;
			cfg_q.add_y         <= RST_ADD_Y;
			cfg_q.modulo_y      <= RST_MODULO_Y;
			cfg_q.frame_columns <= RST_FRAME_COLUMNS;
			cfg_q.frame_lines   <= RST_FRAME_LINES;
			cfg_q.blend_rows    <= RST_BLEND_ROWS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ADD_X:         cfg_q.add_x         <= cfg_data;
				CFG_MODULO_X:      cfg_q.modulo_x      <= cfg_data;
				CFG_ADD_Y:         cfg_q.add_y         <= cfg_data;
				CFG_MODULO_Y:      cfg_q.modulo_y      <= cfg_data;
				CFG_FRAME_COLUMNS: cfg_q.frame_columns <= cfg_data[SIZE_W-1:0];
				CFG_FRAME_LINES:   cfg_q.frame_lines   <= cfg_data[SIZE_W-1:0];
				CFG_BLEND_ROWS:    cfg_q.blend_rows    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// A pixel is taken whenever the request queue has room.
	assign in_stall = q_full;
	assign in_go    = in_valid && !in_stall;

	fdb_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_LINES  (MAX_LINES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_go     (in_go),
		.src_pixel (src_pixel),
		.op_push   (op_push),
		.op_pixel  (op_pixel),
		.op_col    (op_col),
		.op_row    (op_row),
		.op_flags  (op_flags)
	);

	assign q_wdata = {op_pixel, op_col, op_row, op_flags};
	assign {head_pixel, head_col, head_row, head_flags} = q_rdata;

	fdb_fifo #(
		.WIDTH(OP_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (op_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	fdb_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_LINES  (MAX_LINES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head_pixel (head_pixel),
		.head_col   (head_col),
		.head_row   (head_row),
		.head_flags (head_flags),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel),
		.out_x      (out_x),
		.out_y      (out_y),
		.frame_end  (frame_end),
		.stat       (back_stat)
	);

	// A committing request leaves write-back only when the result register can take it.
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(back_stat.go && back_stat.commit) |-> (!out_valid || !out_stall))
		else $error("committed request overwrote a pending result");

	// Forwarded line-buffer data is only ever held for a request in write-back.
	a_fwd_owner: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.fwd |-> back_stat.valid)
		else $error("forward flag set with no request in write-back");

	// The queue is never popped empty nor pushed full.
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_pop || q_not_empty) && (!op_push || !q_full))
		else $error("request queue overflow or underflow");

endmodule
`default_nettype wire

// ----- bench/fdb_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_monitor: output write prediction and comparison for the downscaler
// Follows register writes and accepted pixel requests, predicts every output
// write of the blending downscaler and compares it with what the block sends.
// ----------------------------------------------------------------------------
module fdb_monitor
	import fdb_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	input  wire                  in_valid,
	input  wire                  in_stall,
	input  wire [15:0]           src_pixel,
	input  wire                  out_valid,
	input  wire                  out_stall,
	input  wire [15:0]           out_pixel,
	input  wire [9:0]            out_x,
	input  wire [9:0]            out_y,
	input  wire                  frame_end,
	output int                   pending,
	output int                   failures
);

	typedef struct {
		logic [15:0] pixel;
		logic [9:0]  x;
		logic [9:0]  y;
		logic        last;
	} out_write_t;

	cfg_t             regs;
	logic [ACC_W-1:0] acc_h;
	logic [ACC_W-1:0] acc_v;
	logic [15:0]      run_pix;
	logic             blend_pending;
	logic             row_takes;
	int unsigned      col;
	int unsigned      row;
	int unsigned      dcol;
	int unsigned      drow;
	logic [15:0]      line_mem [DEF_MAX_COLUMNS];
	out_write_t       writes_due[$];

	function automatic logic [15:0] mean565(input logic [15:0] a, input logic [15:0] b);
		int unsigned r;
		int unsigned g;
		int unsigned bl;
		r  = (a[15:11] + b[15:11]) >> 1;
		g  = (a[10:5] + b[10:5]) >> 1;
		bl = (a[4:0] + b[4:0]) >> 1;
		return {r[4:0], g[5:0], bl[4:0]};
	endfunction

	function automatic int unsigned usable_size(input logic [SIZE_W-1:0] v,
			input int unsigned limit);
		if (v == 0) begin
			return 1;
		end
		return (v > limit) ? limit : v;
	endfunction

	// One accumulator step; the threshold is taken off once reached and the
	// sum is held at the top of the 17-bit range.
	function automatic logic [ACC_W-1:0] acc_advance(input logic [ACC_W-1:0] acc,
			input logic [15:0] inc, input logic [15:0] thr, output logic hit);
		int unsigned s;
		s   = acc + inc;
		hit = (s >= thr);
		if (hit) begin
			s = s - thr;
		end
		if (s > 32'h1FFFF) begin
			s = 32'h1FFFF;
		end
		return s[ACC_W-1:0];
	endfunction

	task automatic predict_pixel(input logic [15:0] pix);
		int unsigned cols;
		int unsigned lines;
		logic        end_col;
		logic        end_row;
		logic        hit;
		logic [15:0] value;
		out_write_t  w;
		cols    = usable_size(regs.frame_columns, DEF_MAX_COLUMNS);
		lines   = usable_size(regs.frame_lines, DEF_MAX_LINES);
		end_col = (col + 1 >= cols);
		end_row = (row + 1 >= lines);
		if (col == 0) begin
			acc_v     = acc_advance(acc_v, regs.add_y, regs.modulo_y, hit);
			row_takes = hit || end_row;
		end
		value   = (acc_h >= regs.add_x) ? mean565(run_pix, pix) : pix;
		run_pix = value;
		acc_h   = acc_advance(acc_h, regs.add_x, regs.modulo_x, hit);
		if (hit || end_col) begin
			if (dcol < DEF_MAX_COLUMNS) begin
				if (blend_pending) begin
					value = mean565(line_mem[dcol], value);
				end
				line_mem[dcol] = value;
			end
			if (row_takes) begin
				w.pixel = value;
				w.x     = dcol[9:0];
				w.y     = drow[9:0];
				w.last  = end_col && end_row;
				writes_due.push_back(w);
			end
			if (dcol < DEF_MAX_COLUMNS) begin
				dcol++;
			end
		end
		if (end_col) begin
			col           = 0;
			acc_h         = '0;
			run_pix       = '0;
			dcol          = 0;
			blend_pending = regs.blend_rows && !row_takes;
			if (row_takes && drow < DEF_MAX_LINES) begin
				drow++;
			end
			if (end_row) begin
				row           = 0;
				drow          = 0;
				acc_v         = '0;
				blend_pending = 1'b0;
			end else begin
				row++;
			end
		end else begin
			col++;
		end
	endtask

	task automatic check_write();
		out_write_t want;
		if (writes_due.size() == 0) begin
			failures++;
			if (failures <= 10) begin
				$display("%0t: unexpected output write: pixel %h x %0d y %0d end %0b",
					$realtime, out_pixel, out_x, out_y, frame_end);
			end
		end else begin
			want = writes_due.pop_front();
			if (want.pixel !== out_pixel || want.x !== out_x || want.y !== out_y
					|| want.last !== frame_end) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: output write mismatch: expected pixel %h x %0d y %0d end %0b",
						$realtime, want.pixel, want.x, want.y, want.last);
					$display("%0t:                        got pixel %h x %0d y %0d end %0b",
						$realtime, out_pixel, out_x, out_y, frame_end);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.add_x         = RST_ADD_X;
			regs.modulo_x      = RST_MODULO_X;
			regs.add_y         = RST_ADD_Y;
			regs.modulo_y      = RST_MODULO_Y;
			regs.frame_columns = RST_FRAME_COLUMNS;
			regs.frame_lines   = RST_FRAME_LINES;
			regs.blend_rows    = RST_BLEND_ROWS;
			acc_h              = '0;
			acc_v              = '0;
			run_pix            = '0;
			blend_pending      = 1'b0;
			row_takes          = 1'b0;
			col                = 0;
			row                = 0;
			dcol               = 0;
			drow               = 0;
			writes_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_ADD_X:         regs.add_x = cfg_data;
					CFG_MODULO_X:      regs.modulo_x = cfg_data;
					CFG_ADD_Y:         regs.add_y = cfg_data;
					CFG_MODULO_Y:      regs.modulo_y = cfg_data;
					CFG_FRAME_COLUMNS: regs.frame_columns = cfg_data[SIZE_W-1:0];
					CFG_FRAME_LINES:   regs.frame_lines = cfg_data[SIZE_W-1:0];
					CFG_BLEND_ROWS:    regs.blend_rows = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_pixel(src_pixel);
			end
			if (out_valid && !out_stall) begin
				check_write();
			end
		end
		pending = writes_due.size();
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for fit_downscaler_with_blending
// Drives RGB565 frames through the downscaler under a range of register
// settings, with bursty requests and a stalling receiver; fdb_monitor
// predicts and checks every output write.
// ----------------------------------------------------------------------------
module tb;
	import fdb_pkg::*;

	// Cycles allowed after the last expected write before registers change,
	// since a request that produces no write may still be in flight.
	localparam int QUIET_CYCLES  = 12;
	// Length of the long receiver hold-off that fills the block up.
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PIXELS = 420;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	wire                   in_stall;
	logic [15:0]           src_pixel;
	wire                   out_valid;
	logic                  out_stall;
	wire  [15:0]           out_pixel;
	wire  [9:0]            out_x;
	wire  [9:0]            out_y;
	wire                   frame_end;

	int   pending;
	int   failures;
	int   burst_left;
	int   pixels_sent;
	logic hold_off_req;

	fit_downscaler_with_blending dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_pixel (src_pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_pixel (out_pixel),
		.out_x     (out_x),
		.out_y     (out_y),
		.frame_end (frame_end)
	);

	fdb_monitor mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_pixel (src_pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_pixel (out_pixel),
		.out_x     (out_x),
		.out_y     (out_y),
		.frame_end (frame_end),
		.pending   (pending),
		.failures  (failures)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Effective frame area, with a size of zero counting as one and sizes
	// beyond the line buffer counting as its full width or height.
	function automatic int unsigned frame_area(input logic [SIZE_W-1:0] fc,
			input logic [SIZE_W-1:0] fl);
		int unsigned c;
		int unsigned l;
		c = (fc == 0) ? 1 : ((fc > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : fc);
		l = (fl == 0) ? 1 : ((fl > DEF_MAX_LINES) ? DEF_MAX_LINES : fl);
		return c * l;
	endfunction

	// Mostly uniform pixels, with the odd saturated colour or grey thrown in so
	// that the channel averaging sees its carries and its extremes.
	function automatic logic [15:0] any_pixel();
		case ($urandom_range(0, 15))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'hF800;
			3:       return 16'h07E0;
			4:       return 16'h001F;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	// Offers one pixel request and returns at the falling edge after it has
	// been taken. The sender works in bursts; between bursts it may drop valid,
	// but never while a request is waiting to be accepted.
	task automatic offer_pixel(input logic [15:0] pix);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		in_valid  = 1'b1;
		src_pixel = pix;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
		burst_left--;
		pixels_sent++;
	endtask

	task automatic feed_frame(input int unsigned count);
		repeat (count) begin
			offer_pixel(any_pixel());
		end
	endtask

	// Stops offering and waits for every predicted write to come out, then
	// gives the pipeline a little longer to empty of requests without writes.
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic configure(input logic [15:0] ax, input logic [15:0] mx,
			input logic [15:0] ay, input logic [15:0] my,
			input logic [SIZE_W-1:0] fc, input logic [SIZE_W-1:0] fl, input logic br);
		settle();
		write_reg(CFG_ADD_X, ax);
		write_reg(CFG_MODULO_X, mx);
		write_reg(CFG_ADD_Y, ay);
		write_reg(CFG_MODULO_Y, my);
		write_reg(CFG_FRAME_COLUMNS, {{(CFG_DATA_W-SIZE_W){1'b0}}, fc});
		write_reg(CFG_FRAME_LINES, {{(CFG_DATA_W-SIZE_W){1'b0}}, fl});
		write_reg(CFG_BLEND_ROWS, {{(CFG_DATA_W-1){1'b0}}, br});
	endtask

	// Chooses an increment and threshold pair. Half are ordinary downscale
	// ratios for the given span; the rest cover a zero increment, a zero
	// threshold, an increment well above the threshold (the accumulator then
	// runs into its ceiling), both at 16'hFFFF, and arbitrary 16-bit values.
	task automatic pick_steps(input int unsigned span, output logic [15:0] inc,
			output logic [15:0] thr);
		case ($urandom_range(0, 9))
			0: begin
				inc = '0;
				thr = $urandom_range(1, span + 2);
			end
			1: begin
				inc = $urandom_range(1, span);
				thr = '0;
			end
			2: begin
				inc = $urandom_range(1000, 16'hFFFF);
				thr = $urandom_range(1, 999);
			end
			3: begin
				inc = 16'hFFFF;
				thr = 16'hFFFF;
			end
			4: begin
				inc = $urandom_range(0, 16'hFFFF);
				thr = $urandom_range(0, 16'hFFFF);
			end
			default: begin
				inc = $urandom_range(1, span);
				thr = span;
			end
		endcase
	endtask

	// The receiver stalls on a pattern of its own: spans of no stalling, light
	// and heavy random stalling, and a regular beat. On request it holds off
	// for a long stretch so that the block fills and stalls its input.
	initial begin
		int span;
		int style;
		out_stall = 1'b0;
		span      = 0;
		style     = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall    = 1'b0;
				hold_off_req = 1'b0;
			end else begin
				if (span == 0) begin
					style = $urandom_range(0, 3);
					span  = $urandom_range(8, 80);
				end
				span--;
				case (style)
					0:       out_stall = 1'b0;
					1:       out_stall = ($urandom_range(0, 3) == 0);
					2:       out_stall = ($urandom_range(0, 9) < 7);
					default: out_stall = (span % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		logic [15:0]       ax;
		logic [15:0]       mx;
		logic [15:0]       ay;
		logic [15:0]       my;
		logic [SIZE_W-1:0] fc;
		logic [SIZE_W-1:0] fl;
		int unsigned       random_start;

		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_ADD_X;
		cfg_data     = '0;
		in_valid     = 1'b0;
		src_pixel    = '0;
		hold_off_req = 1'b0;
		burst_left   = 0;
		pixels_sent  = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A 2x2 frame at unit ratio: every pixel is written and committed, so
		// the extreme colours go straight through.
		configure(16'd1, 16'd1, 16'd1, 16'd1, 11'd2, 11'd2, 1'b1);
		offer_pixel(16'h0000);
		offer_pixel(16'hFFFF);
		offer_pixel(16'hF800);
		offer_pixel(16'h07E0);

		// Zero frame sizes act as a single pixel, each one a whole frame; zero
		// increments and thresholds average every pixel and write every one.
		configure(16'd0, 16'd0, 16'd0, 16'd0, 11'd0, 11'd0, 1'b1);
		offer_pixel(16'hFFFF);
		offer_pixel(16'h001F);

		// Every other row commits, and the last one always does: the first row
		// goes into the line buffer and the second row's writes are averaged with it.
		configure(16'd1, 16'd1, 16'd1, 16'd2, 11'd2, 11'd3, 1'b1);
		offer_pixel(16'h07E0);
		offer_pixel(16'hF81F);
		offer_pixel(16'hFFFF);
		offer_pixel(16'h0000);
		offer_pixel(16'h8410);
		offer_pixel(16'h7BEF);

		// The same with blending off: the skipped row is simply dropped.
		configure(16'd1, 16'd1, 16'd1, 16'd2, 11'd2, 11'd2, 1'b0);
		offer_pixel(16'hFFFF);
		offer_pixel(16'h0841);
		offer_pixel(16'hF7DE);
		offer_pixel(16'h0000);

		// Increment far above the threshold: the accumulator saturates, every
		// pixel is written and, once the accumulator reaches the increment, averaged.
		configure(16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 11'd4, 11'd1, 1'b1);
		offer_pixel(16'hFFFF);
		offer_pixel(16'h0000);
		offer_pixel(16'hFFFF);
		offer_pixel(16'h5555);

		// Frame shrunk part way through: after one and a half rows the block
		// is told the frame is two columns by one line, so the next pixel is
		// both past the last column and on the last row and ends the frame.
		configure(16'd1, 16'd2, 16'd1, 16'd2, 11'd4, 11'd3, 1'b1);
		offer_pixel(16'hFFFF);
		offer_pixel(16'hF800);
		offer_pixel(16'h07E0);
		offer_pixel(16'h001F);
		offer_pixel(16'h0000);
		offer_pixel(16'hFFFF);
		settle();
		write_reg(CFG_FRAME_COLUMNS, 16'd2);
		write_reg(CFG_FRAME_LINES, 16'd1);
		offer_pixel(16'hAAAA);

		random_start = pixels_sent;

		// Back-pressure: a frame in which every pixel produces a write, with the
		// receiver holding off for a long stretch while requests keep coming.
		configure(16'd1, 16'd1, 16'd1, 16'd1, 11'd16, 11'd4, 1'b1);
		hold_off_req = 1'b1;
		feed_frame(64);

		// Random frames, mostly small, each under a fresh register setting.
		while (pixels_sent - random_start < RANDOM_PIXELS) begin
			case ($urandom_range(0, 15))
				0:       fc = '0;
				1:       fc = $urandom_range(17, 40);
				default: fc = $urandom_range(1, 16);
			endcase
			fl = ($urandom_range(0, 11) == 0) ? '0 : $urandom_range(1, 6);
			pick_steps(frame_area(fc, 1), ax, mx);
			pick_steps(frame_area(1, fl), ay, my);
			configure(ax, mx, ay, my, fc, fl, $urandom_range(0, 3) != 0);
			feed_frame(frame_area(fc, fl));
		end

		// A width beyond the line buffer: one full-width line.
		configure($urandom_range(1, 64), 16'd1024, 16'd1, 16'd1,
			$urandom_range(1025, 2047), 11'd1, $urandom_range(0, 1));
		feed_frame(DEF_MAX_COLUMNS);

		settle();
		if (failures == 0 && pending == 0) begin
			$display("fit_downscaler_with_blending verification clean");
		end else begin
			$display("fit_downscaler_with_blending verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("fit_downscaler_with_blending verification failed");
		$finish;
	end

endmodule
